// File: rtl/core/qmr_pkg.sv
// Shared types, constants and arithmetic helpers for the quaternion unit.
// Used by quaternion_multiply_rotate and its port checker; no dependencies.

package qmr_pkg;

    // Fixed-point format and internal word widths
    localparam int FRAC_BITS = 16;
    localparam int COMP_W    = 32;
    localparam int PROD_W    = 2 * COMP_W;
    localparam int PAIR_W    = PROD_W + 1;
    localparam int SUM_W     = PROD_W + 2;
    localparam int SH_W      = SUM_W - FRAC_BITS;

    // Action codes
    localparam logic ACT_MUL = 1'b0;
    localparam logic ACT_ROT = 1'b1;

    typedef logic signed [COMP_W-1:0] comp_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [PAIR_W-1:0] pair_t;
    typedef logic signed [SUM_W-1:0]  sum_t;

    typedef struct packed {
        logic  action;
        comp_t a_x;
        comp_t a_y;
        comp_t a_z;
        comp_t a_w;
        comp_t b_x;
        comp_t b_y;
        comp_t b_z;
        comp_t b_w;
    } req_t;

    typedef struct packed {
        comp_t r_x;
        comp_t r_y;
        comp_t r_z;
        comp_t r_w;
        logic  saturated;
    } rsp_t;

    typedef struct packed {
        comp_t val;
        logic  sat;
    } fin_t;

    localparam comp_t COMP_MAX = {1'b0, {(COMP_W-1){1'b1}}};
    localparam comp_t COMP_MIN = {1'b1, {(COMP_W-1){1'b0}}};

    // Half an LSB of the result, added before the arithmetic shift
    localparam sum_t ROUND = {{(SUM_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

    // Term signs, bit k = term k of output component j (x, y, z, w).
    // Term k pairs left operand k with right operand b_index(j, k).
    localparam logic [3:0] NEG_MUL  [4] = '{4'b0100, 4'b0001, 4'b0010, 4'b0111};
    localparam logic [3:0] NEG_CONJ [4] = '{4'b1010, 4'b1100, 4'b1001, 4'b0000};

    function automatic logic [1:0] b_index(input int j, input int k);
        return 2'(j) ^ 2'(k) ^ 2'd3;
    endfunction

    // Signed sum of two products, each optionally negated
    function automatic pair_t pair_sum(input prod_t x, input prod_t y,
                                       input logic nx, input logic ny);
        pair_t xe;
        pair_t ye;
        xe = PAIR_W'(x);
        ye = PAIR_W'(y);
        if (nx)
            xe = -xe;
        if (ny)
            ye = -ye;
        return xe + ye;
    endfunction

    // Final add of the two pair sums plus the rounding offset
    function automatic sum_t quad_sum(input pair_t p, input pair_t q);
        return SUM_W'(p) + SUM_W'(q) + ROUND;
    endfunction

    // Drop the fraction bits and clip to the component range
    function automatic fin_t finish(input sum_t s);
        logic signed [SH_W-1:0]   sh;
        logic [SH_W-COMP_W:0]     hi;
        fin_t                     f;
        sh = SH_W'(s >>> FRAC_BITS);
        hi = sh[SH_W-1:COMP_W-1];
        if ((&hi) || (~|hi)) begin
            f.val = sh[COMP_W-1:0];
            f.sat = 1'b0;
        end
        else begin
            f.val = sh[SH_W-1] ? COMP_MIN : COMP_MAX;
            f.sat = 1'b1;
        end
        return f;
    endfunction

endpackage

// File: rtl/core/quaternion_multiply_rotate.sv
// Quaternion product / vector rotation unit, eight-stage pipeline.
// Depends on qmr_pkg for types, sign tables and rounding helpers.

// The unit accepts one item per clock while req_stall is low and returns its
// results in order. Each item goes through two passes of the
// same four-stage datapath shape: sixteen 32x32 signed multipliers, a stage
// of signed pair sums, a final add with the round-to-nearest offset, and a
// shift-and-clip stage. Action 0 returns the Hamilton product a*b from the
// first pass; action 1 rotates (b_x, b_y, b_z) as a*p*conj(a), the second
// pass multiplying the clipped intermediate by conj(a), with r_w forced to 0.
// Every stage holds its own valid bit and advances when the stage after it
// is empty or moving, so bubbles close up and input is still taken while a
// result waits on a stalled output. The multiplier stages set the clock.

module quaternion_multiply_rotate (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  qmr_pkg::req_t  req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output qmr_pkg::rsp_t  rsp
);

    // Stage control
    logic [8:1] v_reg;
    logic [8:1] adv;

    // Operand arrays from the request
    qmr_pkg::comp_t a_in [4];
    qmr_pkg::comp_t b_in [4];

    // Pass one: product
    logic           act1_reg, act2_reg, act3_reg, act4_reg;
    qmr_pkg::comp_t a1_reg [4];
    qmr_pkg::comp_t a2_reg [4];
    qmr_pkg::comp_t a3_reg [4];
    qmr_pkg::comp_t a4_reg [4];
    qmr_pkg::prod_t prod1_reg [4][4];
    qmr_pkg::pair_t pair2_reg [4][2];
    qmr_pkg::sum_t  sum3_reg [4];
    qmr_pkg::fin_t  fin4 [4];
    qmr_pkg::comp_t t4_reg [4];
    logic           sat4_reg;

    // Pass two: multiply by the conjugate
    logic           act5_reg, act6_reg, act7_reg;
    qmr_pkg::comp_t t5_reg [4];
    qmr_pkg::comp_t t6_reg [4];
    qmr_pkg::comp_t t7_reg [4];
    logic           sat5_reg, sat6_reg, sat7_reg;
    qmr_pkg::prod_t prod5_reg [4][4];
    qmr_pkg::pair_t pair6_reg [4][2];
    qmr_pkg::sum_t  sum7_reg [4];
    qmr_pkg::fin_t  fin8 [4];

    qmr_pkg::rsp_t  rsp_reg;

    // Advance chain: a stage moves when it is empty or its successor moves
    always_comb
    begin
        adv[8] = !v_reg[8] || !rsp_stall;
        for (int k = 7; k >= 1; k--)
        begin
            adv[k] = !v_reg[k] || adv[k+1];
        end
    end

    assign req_stall = !adv[1];
    assign rsp_valid = v_reg[8];
    assign rsp       = rsp_reg;

    // Valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (adv[1])
                v_reg[1] <= req_valid;
            for (int k = 2; k <= 8; k++)
            begin
                if (adv[k])
                    v_reg[k] <= v_reg[k-1];
            end
        end
    end

    // Operands; the rotated vector has no scalar part
    always_comb
    begin
        a_in[0] = req.a_x;
        a_in[1] = req.a_y;
        a_in[2] = req.a_z;
        a_in[3] = req.a_w;
        b_in[0] = req.b_x;
        b_in[1] = req.b_y;
        b_in[2] = req.b_z;
        b_in[3] = (req.action == qmr_pkg::ACT_ROT) ? '0 : req.b_w;
    end

    // Stage 1: a*b products
    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            act1_reg <= req.action;
            for (int j = 0; j < 4; j++)
            begin
                a1_reg[j] <= a_in[j];
                for (int k = 0; k < 4; k++)
                begin
                    prod1_reg[j][k] <= a_in[k] * b_in[qmr_pkg::b_index(j, k)];
                end
            end
        end
    end

    // Stage 2: signed pair sums
    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            act2_reg <= act1_reg;
            for (int j = 0; j < 4; j++)
            begin
                a2_reg[j]       <= a1_reg[j];
                pair2_reg[j][0] <= qmr_pkg::pair_sum(prod1_reg[j][0], prod1_reg[j][1],
                                                     qmr_pkg::NEG_MUL[j][0],
                                                     qmr_pkg::NEG_MUL[j][1]);
                pair2_reg[j][1] <= qmr_pkg::pair_sum(prod1_reg[j][2], prod1_reg[j][3],
                                                     qmr_pkg::NEG_MUL[j][2],
                                                     qmr_pkg::NEG_MUL[j][3]);
            end
        end
    end

    // Stage 3: full sum with rounding offset
    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            act3_reg <= act2_reg;
            for (int j = 0; j < 4; j++)
            begin
                a3_reg[j]   <= a2_reg[j];
                sum3_reg[j] <= qmr_pkg::quad_sum(pair2_reg[j][0], pair2_reg[j][1]);
            end
        end
    end

    // Stage 4: shift and clip the first result
    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            fin4[j] = qmr_pkg::finish(sum3_reg[j]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            act4_reg <= act3_reg;
            sat4_reg <= fin4[0].sat | fin4[1].sat | fin4[2].sat | fin4[3].sat;
            for (int j = 0; j < 4; j++)
            begin
                a4_reg[j] <= a3_reg[j];
                t4_reg[j] <= fin4[j].val;
            end
        end
    end

    // Stage 5: t*conj(a) products
    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            act5_reg <= act4_reg;
            sat5_reg <= sat4_reg;
            for (int j = 0; j < 4; j++)
            begin
                t5_reg[j] <= t4_reg[j];
                for (int k = 0; k < 4; k++)
                begin
                    prod5_reg[j][k] <= t4_reg[k] * a4_reg[qmr_pkg::b_index(j, k)];
                end
            end
        end
    end

    // Stage 6: signed pair sums, conjugate signs
    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            act6_reg <= act5_reg;
            sat6_reg <= sat5_reg;
            for (int j = 0; j < 4; j++)
            begin
                t6_reg[j]       <= t5_reg[j];
                pair6_reg[j][0] <= qmr_pkg::pair_sum(prod5_reg[j][0], prod5_reg[j][1],
                                                     qmr_pkg::NEG_CONJ[j][0],
                                                     qmr_pkg::NEG_CONJ[j][1]);
                pair6_reg[j][1] <= qmr_pkg::pair_sum(prod5_reg[j][2], prod5_reg[j][3],
                                                     qmr_pkg::NEG_CONJ[j][2],
                                                     qmr_pkg::NEG_CONJ[j][3]);
            end
        end
    end

    // Stage 7: full sum with rounding offset
    always_ff @(posedge clk)
    begin
        if (adv[7])
        begin
            act7_reg <= act6_reg;
            sat7_reg <= sat6_reg;
            for (int j = 0; j < 4; j++)
            begin
                t7_reg[j]   <= t6_reg[j];
                sum7_reg[j] <= qmr_pkg::quad_sum(pair6_reg[j][0], pair6_reg[j][1]);
            end
        end
    end

    // Stage 8: clip the rotation result and pick the output
    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            fin8[j] = qmr_pkg::finish(sum7_reg[j]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[8])
        begin
            if (act7_reg == qmr_pkg::ACT_MUL)
            begin
                rsp_reg.r_x       <= t7_reg[0];
                rsp_reg.r_y       <= t7_reg[1];
                rsp_reg.r_z       <= t7_reg[2];
                rsp_reg.r_w       <= t7_reg[3];
                rsp_reg.saturated <= sat7_reg;
            end
            else
            begin
                // w of the rotation is dropped, but a clip there still counts
                rsp_reg.r_x       <= fin8[0].val;
                rsp_reg.r_y       <= fin8[1].val;
                rsp_reg.r_z       <= fin8[2].val;
                rsp_reg.r_w       <= '0;
                rsp_reg.saturated <= sat7_reg | fin8[0].sat | fin8[1].sat
                                     | fin8[2].sat | fin8[3].sat;
            end
        end
    end

endmodule

// File: rtl/core/qmr_checker.sv
// Port-level checks for quaternion_multiply_rotate, bound into that module.
// Depends on qmr_pkg for the result item type.

module qmr_port_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_stall,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input qmr_pkg::rsp_t rsp
);

    // A stalled result stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result item changed while stalled");

    // Input backs up only when every stage is full behind a stalled output
    assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> rsp_valid && rsp_stall)
    else $error("input stalled with room in the pipeline");

    // Reset empties the pipeline
    assert property (@(posedge clk)
        !rst_n |=> !rsp_valid)
    else $error("result item shown during reset");

endmodule

bind quaternion_multiply_rotate qmr_port_checker u_qmr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
